// ===== hw/rtl/sliding_window_median_unit_defines.svh =====
// Assertion macros shared by the sliding window median RTL.
`ifndef SLIDING_WINDOW_MEDIAN_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SWM_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define SWM_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/swm_pkg.sv =====
// Shared constants and types of the sliding window median unit.
package swm_pkg;

  localparam int DEF_MAX_WINDOW  = 64;
  localparam int DEF_SAMPLE_BITS = 32;
  localparam int CFG_BITS        = 7;
  localparam int RESET_WINDOW    = 3;

  // move request a cell shows its neighbors
  typedef struct packed {
    logic mr;  // my word goes to the cell above
    logic ml;  // my word goes to the cell below
  } swm_move_t;

endpackage

// ===== hw/rtl/swm_cell.sv =====
// One slot of the sorted window: value, age and local insert/remove decision.
module swm_cell #(
  parameter int SAMPLE_BITS = swm_pkg::DEF_SAMPLE_BITS,
  parameter int AW          = 6,
  parameter int CW          = 7,
  parameter int IDX         = 0
) (
  input  logic                          clk,
  input  logic                          upd,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [SAMPLE_BITS-1:0] oldest_val,
  input  logic        [AW-1:0]          k_m1,
  input  logic                          full,
  input  logic        [CW-1:0]          fill,
  input  logic signed [SAMPLE_BITS-1:0] left_val,
  input  logic        [AW-1:0]          left_age,
  input  swm_pkg::swm_move_t            left_mv,
  input  logic signed [SAMPLE_BITS-1:0] right_val,
  input  logic        [AW-1:0]          right_age,
  input  swm_pkg::swm_move_t            right_mv,
  output logic signed [SAMPLE_BITS-1:0] val,
  output logic        [AW-1:0]          age,
  output swm_pkg::swm_move_t            mv,
  output logic                          is_old
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic                          valid;
  logic                          gt;
  logic                          above;
  logic                          stay;
  logic signed [SAMPLE_BITS-1:0] val_next;
  logic        [AW-1:0]          age_next;

  assign valid  = MY_IDX < fill;
  assign is_old = full && valid && (age == k_m1);
  // empty slots sort as +inf so the new word lands below them
  assign gt     = !valid || (val > sample);
  // oldest sits lowest among equal values, so >= finds everything above it
  assign above  = full && valid && !is_old && (val >= oldest_val);
  assign mv.mr  = gt && !above && !is_old;
  assign mv.ml  = above && !gt;
  assign stay   = !is_old && (above == gt);

  always_comb begin
    if (right_mv.ml) begin
      val_next = right_val;
      age_next = right_age + AW'(1);
    end else if (left_mv.mr) begin
      val_next = left_val;
      age_next = left_age + AW'(1);
    end else if (stay) begin
      val_next = val;
      age_next = age + AW'(1);
    end else begin
      val_next = sample;
      age_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      val <= val_next;
      age <= age_next;
    end
  end

endmodule

// ===== hw/rtl/swm_out.sv =====
// Median pick from the sorted cells, doubling add and output register.
`include "sliding_window_median_unit_defines.svh"

module swm_out #(
  parameter int SAMPLE_BITS = swm_pkg::DEF_SAMPLE_BITS,
  parameter int MAX_WINDOW  = swm_pkg::DEF_MAX_WINDOW,
  parameter int AW          = 6,
  parameter int CW          = 7,
  parameter int ODW         = 40
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [MAX_WINDOW*SAMPLE_BITS-1:0] vals,
  input  logic [CW-1:0]                     k,
  input  logic                              pend_set,
  output logic                              take_ok,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ODW-1:0]                    m_axis_tdata
);

  logic                          pend;
  logic                          advance;
  logic [AW-1:0]                 lo_idx;
  logic [AW-1:0]                 hi_idx;
  logic signed [SAMPLE_BITS-1:0] lo_val;
  logic signed [SAMPLE_BITS-1:0] hi_val;
  logic signed [SAMPLE_BITS:0]   sum;
  logic        [SAMPLE_BITS:0]   med;

  assign advance = pend && (!m_axis_tvalid || m_axis_tready);
  assign take_ok = !pend || advance;

  // lower and upper middle; equal for odd k
  assign lo_idx = AW'((k - CW'(1)) >> 1);
  assign hi_idx = AW'(k >> 1);
  assign lo_val = vals[lo_idx*SAMPLE_BITS +: SAMPLE_BITS];
  assign hi_val = vals[hi_idx*SAMPLE_BITS +: SAMPLE_BITS];
  assign sum    = {lo_val[SAMPLE_BITS-1], lo_val} + {hi_val[SAMPLE_BITS-1], hi_val};

  always_ff @(posedge clk) begin
    if (rst) begin
      pend          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (pend_set) begin
        pend <= 1'b1;
      end else if (advance) begin
        pend <= 1'b0;
      end
      if (advance) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      med <= sum;
    end
  end

  assign m_axis_tdata = ODW'(med);

  `SWM_ASSERT_NOW(a_stall_blocks, clk, rst, pend && m_axis_tvalid && !m_axis_tready, !take_ok, "input taken while result stalled")
  `SWM_ASSERT_NEXT(a_pend_follows, clk, rst, pend_set, pend, "result lost after window update")

endmodule

// ===== hw/rtl/sliding_window_median_unit.sv =====
// Sliding window running median: top level with fill control and cell chain.
// Streams signed samples and returns twice the median of the last K samples
// (sum of the two middle values for even K, double the middle for odd K).
// K comes from cfg_wdata (0 reads as 1, values above MAX_WINDOW saturate);
// a write restarts the window, as does tuser=1 on a sample. The window is a
// chain of MAX_WINDOW cells kept in ascending order: each accepted sample
// is placed in a single update of all cells, evicting the oldest entry once
// the window is full, every cell deciding from its neighbors' compare results.
// A sample is taken every cycle unless the input stalls; each result is held
// as pending and then registered into the output register, and the input
// stalls only while that register holds an untaken word and another result
// is waiting behind it. The first K-1 samples after a restart give no result.
`include "sliding_window_median_unit_defines.svh"

module sliding_window_median_unit #(
  parameter int MAX_WINDOW  = swm_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = swm_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [swm_pkg::CFG_BITS-1:0]           cfg_wdata,     // window_size
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,  // sample
  input  logic [0:0]                             s_axis_tuser,  // start_req
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [((SAMPLE_BITS+1+7)/8)*8-1:0]     m_axis_tdata   // median_x2
);

  localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW    = $clog2(MAX_WINDOW + 1);
  localparam int ODW   = ((SAMPLE_BITS + 1 + 7) / 8) * 8;
  localparam int K_RST = (swm_pkg::RESET_WINDOW > MAX_WINDOW) ? MAX_WINDOW
                                                              : swm_pkg::RESET_WINDOW;

  logic [CW-1:0]                 k;
  logic [CW-1:0]                 fill;
  logic [CW-1:0]                 fill_eff;
  logic [CW-1:0]                 k_wr;
  logic                          full;
  logic                          accept;
  logic                          has_res;
  logic                          take_ok;
  logic [AW-1:0]                 k_m1;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic signed [SAMPLE_BITS-1:0] oldest_val;

  logic signed [SAMPLE_BITS-1:0] cval [MAX_WINDOW];
  logic        [AW-1:0]          cage [MAX_WINDOW];
  swm_pkg::swm_move_t            cmv  [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]         old_vec;
  logic [MAX_WINDOW*SAMPLE_BITS-1:0] vals_flat;

  assign sample        = s_axis_tdata[SAMPLE_BITS-1:0];
  assign s_axis_tready = take_ok;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign fill_eff = (s_axis_tuser[0] || (fill > k)) ? '0 : fill;
  assign full     = (fill_eff == k);
  assign has_res  = full || ((fill_eff + CW'(1)) == k);
  assign k_m1     = AW'(k - CW'(1));

  always_comb begin
    if (cfg_wdata == '0) begin
      k_wr = CW'(1);
    end else if (32'(cfg_wdata) > 32'(MAX_WINDOW)) begin
      k_wr = CW'(MAX_WINDOW);
    end else begin
      k_wr = CW'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k    <= CW'(K_RST);
      fill <= '0;
    end else if (cfg_we) begin
      k    <= k_wr;
      fill <= '0;
    end else if (accept) begin
      fill <= full ? k : fill_eff + CW'(1);
    end
  end

  // value of the entry about to be evicted (one-hot select)
  always_comb begin
    oldest_val = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      oldest_val = oldest_val | ({SAMPLE_BITS{old_vec[i]}} & cval[i]);
    end
  end

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] lv;
    logic signed [SAMPLE_BITS-1:0] rv;
    logic        [AW-1:0]          la;
    logic        [AW-1:0]          ra;
    swm_pkg::swm_move_t            lm;
    swm_pkg::swm_move_t            rm;

    if (i == 0) begin : g_lo_end
      assign lv = '0;
      assign la = '0;
      assign lm = '0;
    end else begin : g_lo_link
      assign lv = cval[i-1];
      assign la = cage[i-1];
      assign lm = cmv[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_hi_end
      assign rv = '0;
      assign ra = '0;
      assign rm = '0;
    end else begin : g_hi_link
      assign rv = cval[i+1];
      assign ra = cage[i+1];
      assign rm = cmv[i+1];
    end

    swm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .AW          (AW),
      .CW          (CW),
      .IDX         (i)
    ) u_cell (
      .clk        (clk),
      .upd        (accept),
      .sample     (sample),
      .oldest_val (oldest_val),
      .k_m1       (k_m1),
      .full       (full),
      .fill       (fill_eff),
      .left_val   (lv),
      .left_age   (la),
      .left_mv    (lm),
      .right_val  (rv),
      .right_age  (ra),
      .right_mv   (rm),
      .val        (cval[i]),
      .age        (cage[i]),
      .mv         (cmv[i]),
      .is_old     (old_vec[i])
    );

    assign vals_flat[i*SAMPLE_BITS +: SAMPLE_BITS] = cval[i];
  end

  swm_out #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_WINDOW  (MAX_WINDOW),
    .AW          (AW),
    .CW          (CW),
    .ODW         (ODW)
  ) u_out (
    .clk           (clk),
    .rst           (rst),
    .vals          (vals_flat),
    .k             (k),
    .pend_set      (accept && has_res),
    .take_ok       (take_ok),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  `SWM_ASSERT_NOW(a_fill_le_k, clk, rst, 1'b1, fill <= k, "fill count above window size")
  `SWM_ASSERT_NOW(a_k_range, clk, rst, 1'b1, (k != '0) && (32'(k) <= 32'(MAX_WINDOW)), "window size out of range")
  `SWM_ASSERT_NOW(a_one_oldest, clk, rst, accept && full, $onehot(old_vec), "full window without a single oldest entry")

endmodule
